// ===== design/byte_pattern_search_replace_macros.svh =====
// Assertion macros used by the search and replace checker.
`ifndef BYTE_PATTERN_SEARCH_REPLACE_MACROS_SVH
`define BYTE_PATTERN_SEARCH_REPLACE_MACROS_SVH

// Checked at every edge outside reset.
`define BPSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every edge, reset included.
`define BPSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bpsr_pkg.sv =====
// Package with types, constants and helpers for the byte pattern search and replace block.
package bpsr_pkg;

  localparam int MAX_KEY_BYTES_DEF = 8;
  localparam int KEY_BYTES_W = 64;
  localparam int ADDR_W = 32;
  localparam int HIT_W = 32;
  localparam int KEY_WIDTH_REG_W = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int OUT_DEPTH = 4;

  typedef logic [2:0] key_idx_t;
  typedef logic [1:0] out_ptr_t;
  typedef logic [2:0] out_cnt_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_KEY_WIDTH   = 2'd0,
    CFG_KEY_BYTES   = 2'd1,
    CFG_REPL_BYTES  = 2'd2,
    CFG_KEY_LOC     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic                   is_write;
    logic [ADDR_W-1:0]      write_address;
    logic [KEY_BYTES_W-1:0] write_data;
    logic [HIT_W-1:0]       hit_count;
    logic                   last_result;
  } result_t;

  function automatic logic [KEY_BYTES_W-1:0] byte_mask(input logic [3:0] width);
    logic [KEY_BYTES_W-1:0] mask;
    mask = '0;
    for (int b = 0; b < KEY_BYTES_W / 8; b++) begin
      mask[8*b +: 8] = (4'(b) < width) ? 8'hFF : 8'h00;
    end
    return mask;
  endfunction

endpackage

// ===== design/bpsr_cell.sv =====
// One window cell: holds one byte of the sliding window and compares its incoming byte.
module bpsr_cell (
  input  logic       clk,
  input  logic       shift_en,
  input  logic       clear,
  input  logic       active,
  input  logic [7:0] byte_in,
  input  logic [7:0] key_byte,
  output logic [7:0] byte_q,
  output logic       eq
);

  assign eq = !active || (byte_in == key_byte);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_q <= clear ? 8'h00 : byte_in;
    end
  end

endmodule

// ===== design/bpsr_result_fifo.sv =====
// Result queue that takes up to two result words per cycle and releases one.
module bpsr_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_n,
  input  bpsr_pkg::result_t data0,
  input  bpsr_pkg::result_t data1,
  input  logic              pop,
  output bpsr_pkg::result_t head,
  output bpsr_pkg::out_cnt_t count
);

  bpsr_pkg::result_t  mem [bpsr_pkg::OUT_DEPTH];
  bpsr_pkg::out_ptr_t wr_ptr;
  bpsr_pkg::out_ptr_t rd_ptr;

  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= data0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + bpsr_pkg::out_ptr_t'(1)] <= data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + bpsr_pkg::out_ptr_t'(push_n);
      rd_ptr <= rd_ptr + bpsr_pkg::out_ptr_t'(pop);
      count  <= count + bpsr_pkg::out_cnt_t'(push_n) - bpsr_pkg::out_cnt_t'(pop);
    end
  end

endmodule

// ===== design/byte_pattern_search_replace.sv =====
// Byte pattern search and replace: takes one byte per cycle and compares it in the cycle it
// arrives, through a chain of MAX_KEY_BYTES window cells that each hold one window byte and
// compare in parallel. A match not skipped and clear of the key's copy emits one write word
// and the region's last byte emits a summary word; these go into a four-entry result queue,
// and the input stalls while fewer than two entries are free. A byte that yields zero or one
// word sustains one byte per cycle when the output is not stalled; a byte with a write and a
// summary pushes two words. Configuration writes are always taken and act on the next byte.
module byte_pattern_search_replace #(
  parameter int MAX_KEY_BYTES = bpsr_pkg::MAX_KEY_BYTES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [7:0]                           byte_value,
  input  logic [bpsr_pkg::ADDR_W-1:0]          byte_address,
  input  logic                                 end_of_region,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 is_write,
  output logic [bpsr_pkg::ADDR_W-1:0]          write_address,
  output logic [bpsr_pkg::KEY_BYTES_W-1:0]     write_data,
  output logic [bpsr_pkg::HIT_W-1:0]           hit_count,
  output logic                                 last_result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bpsr_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [bpsr_pkg::KEY_BYTES_W-1:0]     cfg_data
);

  localparam int FILL_W = $clog2(MAX_KEY_BYTES + 1);
  localparam int SKIP_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  logic [bpsr_pkg::KEY_WIDTH_REG_W-1:0] key_width;
  logic [bpsr_pkg::KEY_BYTES_W-1:0]     key_bytes;
  logic [bpsr_pkg::KEY_BYTES_W-1:0]     replacement_bytes;
  logic [bpsr_pkg::ADDR_W-1:0]          key_location;

  logic [FILL_W-1:0]             fill_count;
  logic [FILL_W-1:0]             fill_next;
  logic [SKIP_W-1:0]             skip_count;
  logic [bpsr_pkg::HIT_W-1:0]    hits_so_far;
  logic [bpsr_pkg::HIT_W-1:0]    hits_inc;

  logic [FILL_W-1:0]             width_eff;
  logic                          in_accept;
  logic                          enough;
  logic                          match;
  logic                          overlap;
  logic                          hit;
  logic [bpsr_pkg::ADDR_W-1:0]   start_addr;
  logic [bpsr_pkg::ADDR_W:0]     start_ext;
  logic [bpsr_pkg::ADDR_W:0]     key_loc_ext;
  logic [bpsr_pkg::ADDR_W:0]     width_ext;

  logic [7:0]                    cell_in [MAX_KEY_BYTES];
  logic [7:0]                    cell_q  [MAX_KEY_BYTES];
  logic [MAX_KEY_BYTES-1:0]      cell_eq;

  bpsr_pkg::result_t             res0;
  bpsr_pkg::result_t             res1;
  bpsr_pkg::result_t             wr_res;
  bpsr_pkg::result_t             sum_res;
  bpsr_pkg::result_t             head;
  bpsr_pkg::out_cnt_t            q_count;
  logic [1:0]                    push_n;
  logic                          pop;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_width         <= bpsr_pkg::KEY_WIDTH_REG_W'(1);
      key_bytes         <= '0;
      replacement_bytes <= '0;
      key_location      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bpsr_pkg::cfg_idx_t'(cfg_index))
        bpsr_pkg::CFG_KEY_WIDTH:  key_width <= cfg_data[bpsr_pkg::KEY_WIDTH_REG_W-1:0];
        bpsr_pkg::CFG_KEY_BYTES:  key_bytes <= cfg_data;
        bpsr_pkg::CFG_REPL_BYTES: replacement_bytes <= cfg_data;
        bpsr_pkg::CFG_KEY_LOC:    key_location <= cfg_data[bpsr_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (key_width == '0) begin
      width_eff = FILL_W'(1);
    end else if (key_width > bpsr_pkg::KEY_WIDTH_REG_W'(MAX_KEY_BYTES)) begin
      width_eff = FILL_W'(MAX_KEY_BYTES);
    end else begin
      width_eff = FILL_W'(key_width);
    end
  end

  for (genvar i = 0; i < MAX_KEY_BYTES; i++) begin : g_cell
    logic            active;
    bpsr_pkg::key_idx_t kidx;

    if (i == 0) begin : g_head
      assign cell_in[i] = byte_value;
    end else begin : g_link
      assign cell_in[i] = cell_q[i-1];
    end

    assign active = FILL_W'(i) < width_eff;
    assign kidx   = bpsr_pkg::key_idx_t'(4'(width_eff) - 4'(1) - 4'(i));

    bpsr_cell u_cell (
      .clk      (clk),
      .shift_en (in_accept),
      .clear    (end_of_region),
      .active   (active),
      .byte_in  (cell_in[i]),
      .key_byte (key_bytes[8*kidx +: 8]),
      .byte_q   (cell_q[i]),
      .eq       (cell_eq[i])
    );
  end

  assign match       = &cell_eq;
  assign fill_next   = (fill_count < FILL_W'(MAX_KEY_BYTES)) ? fill_count + FILL_W'(1)
                                                             : fill_count;
  assign enough      = fill_next >= width_eff;
  assign start_addr  = byte_address - bpsr_pkg::ADDR_W'(width_eff) + bpsr_pkg::ADDR_W'(1);
  assign start_ext   = {1'b0, start_addr};
  assign key_loc_ext = {1'b0, key_location};
  assign width_ext   = (bpsr_pkg::ADDR_W + 1)'(width_eff);
  assign overlap     = (start_ext < key_loc_ext + width_ext) &&
                       (key_loc_ext < start_ext + width_ext);
  assign hit         = enough && (skip_count == '0) && match && !overlap;
  assign hits_inc    = hit ? hits_so_far + bpsr_pkg::HIT_W'(1) : hits_so_far;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      skip_count  <= '0;
      hits_so_far <= '0;
    end else if (in_accept) begin
      if (end_of_region) begin
        fill_count  <= '0;
        skip_count  <= '0;
        hits_so_far <= '0;
      end else begin
        fill_count  <= fill_next;
        hits_so_far <= hits_inc;
        if (hit) begin
          skip_count <= SKIP_W'(width_eff - FILL_W'(1));
        end else if (enough && skip_count != '0) begin
          skip_count <= skip_count - SKIP_W'(1);
        end
      end
    end
  end

  always_comb begin
    wr_res.is_write      = 1'b1;
    wr_res.write_address = start_addr;
    wr_res.write_data    = replacement_bytes & bpsr_pkg::byte_mask(4'(width_eff));
    wr_res.hit_count     = hits_inc;
    wr_res.last_result   = 1'b0;

    sum_res.is_write      = 1'b0;
    sum_res.write_address = '0;
    sum_res.write_data    = '0;
    sum_res.hit_count     = hits_inc;
    sum_res.last_result   = 1'b1;

    res0   = hit ? wr_res : sum_res;
    res1   = sum_res;
    push_n = in_accept ? (2'(hit) + 2'(end_of_region)) : 2'd0;
  end

  assign pop = out_valid && !out_stall;

  bpsr_result_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .data0  (res0),
    .data1  (res1),
    .pop    (pop),
    .head   (head),
    .count  (q_count)
  );

  assign out_valid     = q_count != '0;
  assign in_stall      = q_count > bpsr_pkg::out_cnt_t'(bpsr_pkg::OUT_DEPTH - 2);
  assign is_write      = head.is_write;
  assign write_address = head.write_address;
  assign write_data    = head.write_data;
  assign hit_count     = head.hit_count;
  assign last_result   = head.last_result;

endmodule

// ===== design/bpsr_checker.sv =====
// Port checker for the byte pattern search and replace block, with its bind statement.
`include "byte_pattern_search_replace_macros.svh"

module bpsr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic                             is_write,
  input logic [bpsr_pkg::ADDR_W-1:0]      write_address,
  input logic [bpsr_pkg::KEY_BYTES_W-1:0] write_data,
  input logic [bpsr_pkg::HIT_W-1:0]       hit_count,
  input logic                             last_result
);

  `BPSR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(write_address) && $stable(write_data) && $stable(hit_count), "Stalled output word changed.")
  `BPSR_ASSERT(a_kind_excl, out_valid |-> (is_write != last_result), "Output word is neither a write nor a summary.")
  `BPSR_ASSERT(a_summary_zero, out_valid && last_result |-> write_address == '0 && write_data == '0, "Summary word carries a nonzero address or data.")
  `BPSR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "Output valid right after reset.")

endmodule

bind byte_pattern_search_replace bpsr_checker u_bpsr_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Testbench for the byte pattern search and replace block: scanned regions checked word by word.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 10;

  typedef struct {
    logic [7:0]  value;
    logic [31:0] addr;
    logic        eor;
  } scan_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_value = '0;
  logic [31:0] byte_address = '0;
  logic        end_of_region = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        is_write;
  logic [31:0] write_address;
  logic [63:0] write_data;
  logic [31:0] hit_count;
  logic        last_result;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  scan_byte_t         pending_bytes[$];
  bpsr_pkg::result_t  expected_words[$];

  logic [3:0]  kw_reg = 4'd1;
  logic [63:0] key_reg = '0;
  logic [63:0] repl_reg = '0;
  logic [31:0] loc_reg = '0;

  logic [7:0]  window [8] = '{default: '0};
  int          fill_cnt = 0;
  int          skip_cnt = 0;
  logic [31:0] hits = '0;

  int errors = 0;
  int cycles = 0;
  int src_gap = 0;
  int snk_gap = 0;
  bit src_idle_en = 1'b0;
  bit snk_idle_en = 1'b0;
  bit src_busy = 1'b0;

  byte_pattern_search_replace dut (.*);

  always #10 clk = ~clk;

  function automatic int eff_width();
    if (kw_reg == 4'd0) return 1;
    if (kw_reg > 4'd8) return 8;
    return int'(kw_reg);
  endfunction

  function automatic void predict_scan(input scan_byte_t b);
    int                 w;
    bit                 hit;
    logic [31:0]        start;
    logic [33:0]        s;
    logic [33:0]        k;
    bpsr_pkg::result_t  r;
    w = eff_width();
    for (int i = 7; i > 0; i--) window[i] = window[i-1];
    window[0] = b.value;
    if (fill_cnt < 8) fill_cnt++;
    if (fill_cnt >= w) begin
      if (skip_cnt > 0) begin
        skip_cnt--;
      end else begin
        hit = 1'b1;
        for (int i = 0; i < w; i++) begin
          if (window[w-1-i] != key_reg[8*i +: 8]) hit = 1'b0;
        end
        start = b.addr - 32'(w - 1);
        s = {2'b00, start};
        k = {2'b00, loc_reg};
        if (hit && !(s < k + 34'(w) && k < s + 34'(w))) begin
          hits++;
          skip_cnt = w - 1;
          r.is_write = 1'b1;
          r.write_address = start;
          r.write_data = (w == 8) ? repl_reg : repl_reg & ((64'd1 << (8 * w)) - 64'd1);
          r.hit_count = hits;
          r.last_result = 1'b0;
          expected_words.push_back(r);
        end
      end
    end
    if (b.eor) begin
      r = '{is_write: 1'b0, write_address: '0, write_data: '0, hit_count: hits,
            last_result: 1'b1};
      expected_words.push_back(r);
      window = '{default: '0};
      fill_cnt = 0;
      skip_cnt = 0;
      hits = '0;
    end
  endfunction

  always @(posedge clk) begin
    scan_byte_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      src_busy = 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_scan('{byte_value, byte_address, end_of_region});
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
          src_busy = 1'b0;
        end else if (src_idle_en && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 13);
          in_valid <= 1'b0;
          src_busy = 1'b0;
        end else if (pending_bytes.size() > 0) begin
          nxt = pending_bytes.pop_front();
          in_valid <= 1'b1;
          byte_value <= nxt.value;
          byte_address <= nxt.addr;
          end_of_region <= nxt.eor;
          src_busy = 1'b1;
        end else begin
          in_valid <= 1'b0;
          src_busy = 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    bpsr_pkg::result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: is_write %b hit_count %0d", is_write, hit_count);
          errors++;
        end else begin
          want = expected_words.pop_front();
          if (is_write !== want.is_write) begin
            $error("is_write: expected %b, actual %b", want.is_write, is_write);
            errors++;
          end
          if (write_address !== want.write_address) begin
            $error("write_address: expected %h, actual %h", want.write_address, write_address);
            errors++;
          end
          if (write_data !== want.write_data) begin
            $error("write_data: expected %h, actual %h", want.write_data, write_data);
            errors++;
          end
          if (hit_count !== want.hit_count) begin
            $error("hit_count: expected %0d, actual %0d", want.hit_count, hit_count);
            errors++;
          end
          if (last_result !== want.last_result) begin
            $error("last_result: expected %b, actual %b", want.last_result, last_result);
            errors++;
          end
        end
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_stall <= 1'b1;
      end else if (snk_idle_en && $urandom_range(0, 5) == 0) begin
        snk_gap = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_drain();
    while (pending_bytes.size() != 0 || src_busy || expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bpsr_pkg::cfg_idx_t idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      bpsr_pkg::CFG_KEY_WIDTH:  kw_reg = data[3:0];
      bpsr_pkg::CFG_KEY_BYTES:  key_reg = data;
      bpsr_pkg::CFG_REPL_BYTES: repl_reg = data;
      bpsr_pkg::CFG_KEY_LOC:    loc_reg = data[31:0];
      default: ;
    endcase
  endtask

  task automatic push_key(input logic [31:0] base, input int n, input bit eor_last);
    for (int i = 0; i < n; i++) begin
      pending_bytes.push_back('{key_reg[8*i +: 8], base + 32'(i), eor_last && i == n - 1});
    end
  endtask

  task automatic random_phase(input int target, input bit quiet);
    int          kwv;
    int          made;
    int          len;
    int          w;
    int          run;
    int          mode;
    logic [63:0] data;
    logic [31:0] a;
    logic [7:0]  v;
    bit          close;
    wait_drain();
    mode = $urandom_range(0, 3);
    src_idle_en = !quiet && (mode == 0 || mode == 1);
    snk_idle_en = !quiet && (mode == 0 || mode == 2);
    case ($urandom_range(0, 7))
      0: kwv = 1;
      1: kwv = 8;
      2: kwv = 0;
      3: kwv = 15;
      4: kwv = 9;
      default: kwv = $urandom_range(1, 8);
    endcase
    data = 64'(kwv);
    if ($urandom_range(0, 3) == 0) data = data | ({$urandom, $urandom} << 4);
    write_reg(bpsr_pkg::CFG_KEY_WIDTH, data);
    case ($urandom_range(0, 7))
      0, 1: data = {8{8'($urandom)}};
      2: data = '1;
      3: data = '0;
      default: data = {$urandom, $urandom};
    endcase
    write_reg(bpsr_pkg::CFG_KEY_BYTES, data);
    case ($urandom_range(0, 5))
      0: data = '1;
      1: data = '0;
      default: data = {$urandom, $urandom};
    endcase
    write_reg(bpsr_pkg::CFG_REPL_BYTES, data);
    case ($urandom_range(0, 7))
      0: data = {32'($urandom), 32'h0000_0000};
      1: data = {32'($urandom), 32'hFFFF_FFFF};
      default: data = {$urandom, $urandom};
    endcase
    write_reg(bpsr_pkg::CFG_KEY_LOC, data);
    cfg_valid <= 1'b0;
    made = 0;
    w = eff_width();
    while (made < target) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, w) : $urandom_range(w, 40);
      if (len > target - made) len = target - made;
      case ($urandom_range(0, 3))
        0, 1: a = loc_reg - 32'($urandom_range(0, 16));
        2: a = $urandom;
        default: a = 32'hFFFF_FFF0 + 32'($urandom_range(0, 15));
      endcase
      close = (made + len < target) || ($urandom_range(0, 3) != 0);
      run = -1;
      for (int j = 0; j < len; j++) begin
        if (j > 0) a = ($urandom_range(0, 39) == 0) ? 32'($urandom) : a + 32'd1;
        if (run < 0 && ($urandom_range(0, 5) == 0 || (a == loc_reg && $urandom_range(0, 1) == 1)))
          run = 0;
        if (run >= 0) begin
          v = key_reg[8*run +: 8];
          run++;
          if (run >= w) run = -1;
        end else if ($urandom_range(0, 1) == 1) begin
          v = key_reg[8*$urandom_range(0, w - 1) +: 8];
        end else begin
          v = 8'($urandom);
        end
        pending_bytes.push_back('{v, a, close && j == len - 1});
      end
      made += len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;

    // Reset settings: a match on the key's own address is skipped, the next one replaced.
    pending_bytes.push_back('{8'h00, 32'h0000_0000, 1'b0});
    pending_bytes.push_back('{8'h00, 32'h0000_0001, 1'b0});
    pending_bytes.push_back('{8'hFF, 32'h0000_0002, 1'b1});
    pending_bytes.push_back('{8'hFF, 32'hFFFF_FFFF, 1'b1});

    // Full width key whose window wraps the address space and overlaps the key's copy,
    // then a region shorter than the key.
    wait_drain();
    write_reg(bpsr_pkg::CFG_KEY_WIDTH, 64'd8);
    write_reg(bpsr_pkg::CFG_KEY_BYTES, 64'h8877_6655_4433_2211);
    write_reg(bpsr_pkg::CFG_REPL_BYTES, 64'hFEDC_BA98_7654_3210);
    write_reg(bpsr_pkg::CFG_KEY_LOC, 64'h0000_0000_FFFF_FFFC);
    cfg_valid <= 1'b0;
    push_key(32'hFFFF_FFFA, 8, 1'b0);
    pending_bytes.push_back('{8'h00, 32'h0000_0002, 1'b1});
    push_key(32'h0000_0100, 3, 1'b1);

    // A wrapped window start is compared unwrapped against the key's copy.
    wait_drain();
    write_reg(bpsr_pkg::CFG_KEY_LOC, 64'd0);
    cfg_valid <= 1'b0;
    push_key(32'hFFFF_FFFC, 8, 1'b1);

    // Zero key width acts as one byte; the region is left open across the next settings.
    wait_drain();
    write_reg(bpsr_pkg::CFG_KEY_WIDTH, 64'd0);
    write_reg(bpsr_pkg::CFG_KEY_BYTES, 64'h0000_0000_0000_00AA);
    cfg_valid <= 1'b0;
    pending_bytes.push_back('{8'hAA, 32'h0000_0010, 1'b0});
    pending_bytes.push_back('{8'hAA, 32'h0000_0011, 1'b0});

    for (int p = 0; p < 20; p++) random_phase(57, p >= 18);

    wait_drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/bpsr_pkg.sv
design/bpsr_cell.sv
design/bpsr_result_fifo.sv
design/byte_pattern_search_replace.sv
design/bpsr_checker.sv
tb/sv/tb_top.sv
